[src/cdnc_pkg.sv]
`default_nettype none

package cdnc_pkg;

  // Field widths
  localparam int DN_W    = 15;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;

  // Default first year of the day count (1 January is day 1)
  localparam int BASE_YEAR_DEF = 2020;

  localparam int DAYS_COMMON = 365;

  // floor(q / 25) == (q * RECIP25) >> 17 for every q below 1024
  localparam int RECIP25 = 5243;

  typedef struct packed {
    logic                 opcode;
    logic [YEAR_W-1:0]    year_in;
    logic [MONTH_W-1:0]   month_in;
    logic [DAY_W-1:0]     day_in;
    logic [DN_W-1:0]      day_number_in;
  } in_t;

  typedef struct packed {
    logic [DN_W-1:0]      day_number_out;
    logic [YEAR_W-1:0]    year_out;
    logic [MONTH_W-1:0]   month_out;
    logic [DAY_W-1:0]     day_out;
  } out_t;

  // Opcodes
  localparam logic OP_DATE_TO_NUM = 1'b0;
  localparam logic OP_NUM_TO_DATE = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture input transfer
    logic div_prev;  // leap count through year-1, whole-year product
    logic div_cur;   // leap flag of the input year
    logic d_sum;     // final date-to-number sum into result register
    logic n_step;    // one year of the year walk
    logic n_fix;     // day-zero correction, leap flag of final year
    logic n_month;   // month search and day into result register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic opcode;
    logic walk_done;
  } dp_sts_t;

  // Days before month index 0..11 (January is 0)
  function automatic logic [8:0] days_before(input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[src/cdnc_dpath.sv]
`default_nettype none

module cdnc_dpath import cdnc_pkg::*; #(
  parameter int BASE_YEAR = BASE_YEAR_DEF
) (
  input  wire logic    clk_i,
  input  wire in_t     in_i,
  input  wire dp_cmd_t cmd_i,
  output dp_sts_t      sts_o,
  output out_t         out_o
);

  // Upper bound on the year walk from a 15-bit day number
  localparam int WalkMax   = 32767 / DAYS_COMMON + 2;
  localparam int YearBits  = $clog2(BASE_YEAR + WalkMax + 1);
  localparam int YearW     = (YearBits > YEAR_W) ? YearBits : YEAR_W;
  localparam int PrevYear  = BASE_YEAR - 1;
  localparam int BaseLeaps = PrevYear / 4 - PrevYear / 100 + PrevYear / 400;
  localparam logic PrevLeap = ((PrevYear % 4) == 0) &&
                              (((PrevYear % 100) != 0) || ((PrevYear % 400) == 0));
  localparam logic [8:0] BaseC400 = 9'(BASE_YEAR % 400);

  // Captured input
  logic                opcode_q;
  logic [YEAR_W-1:0]   year_in_q;
  logic [MONTH_W-1:0]  month_q;
  logic [DAY_W-1:0]    day_in_q;

  // Date-to-number partial results
  logic [9:0]          lp_q;
  logic [DN_W-1:0]     prod_q;
  logic                lyin_q;

  // Number-to-date walk state
  logic [DN_W-1:0]     n_q;
  logic [YearW-1:0]    year_q;
  logic [8:0]          c400_q;
  logic                prevleap_q;
  logic                ly_q;

  out_t                out_q;

  // Month clamp at capture
  logic [MONTH_W-1:0]  month_clamp;
  always_comb begin
    if (in_i.month_in == 4'd0) begin
      month_clamp = 4'd1;
    end else if (in_i.month_in > 4'd12) begin
      month_clamp = 4'd12;
    end else begin
      month_clamp = in_i.month_in;
    end
  end

  // Divide-by-100 unit, shared by year-1 and year
  logic [YEAR_W-1:0] opnd;
  logic [9:0]        quo4;
  logic [22:0]       recip;
  logic [5:0]        quo100;
  logic              is_m100;
  logic              is_m400;
  logic              is_leap;
  logic [9:0]        leaps;

  assign opnd    = cmd_i.div_prev ? (year_in_q - 12'd1) : year_in_q;
  assign quo4    = opnd[11:2];
  assign recip   = 23'(quo4) * 23'(RECIP25);
  assign quo100  = recip[22:17];
  assign is_m100 = (opnd[1:0] == 2'b00) && (quo4 == ({4'b0, quo100} * 10'd25));
  assign is_m400 = is_m100 && (quo100[1:0] == 2'b00);
  assign is_leap = (opnd[1:0] == 2'b00) && (!is_m100 || is_m400);
  assign leaps   = quo4 - 10'(quo100) + 10'(quo100[5:2]);

  // Whole-year product
  logic [DN_W-1:0] diff;
  logic [DN_W-1:0] prod_d;
  assign diff   = 15'(year_in_q) - 15'(BASE_YEAR);
  assign prod_d = diff * 15'(DAYS_COMMON);

  // Date-to-number final sum
  logic            after_base;
  logic [DN_W-1:0] whole;
  logic [DN_W-1:0] dn;
  assign after_base = YearW'(year_in_q) > YearW'(BASE_YEAR);
  assign whole = after_base ? (prod_q + 15'(lp_q) - 15'(BaseLeaps)) : '0;
  assign dn    = whole + 15'(days_before(month_q - 4'd1)) +
                 15'((month_q > 4'd2) && lyin_q) + 15'(day_in_q);

  // Leap flag of the walked year from its position in the 400-year cycle
  logic c400_leap;
  assign c400_leap = (c400_q[1:0] == 2'b00) &&
                     !(c400_q inside {9'd100, 9'd200, 9'd300});

  // Month search: first month whose last day reaches the remaining count
  logic [MONTH_W-1:0] mon;
  logic [DN_W-1:0]    day_rem;
  always_comb begin
    mon = 4'd12;
    for (int m = 11; m >= 1; m--) begin
      if ((15'(days_before(4'(m))) + 15'(ly_q && (m > 1))) >= n_q) begin
        mon = 4'(m);
      end
    end
    day_rem = n_q - 15'(ly_q && (mon > 4'd2)) - 15'(days_before(mon - 4'd1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      opcode_q   <= in_i.opcode;
      year_in_q  <= in_i.year_in;
      month_q    <= month_clamp;
      day_in_q   <= in_i.day_in;
      n_q        <= in_i.day_number_in;
      year_q     <= YearW'(BASE_YEAR);
      c400_q     <= BaseC400;
      prevleap_q <= PrevLeap;
    end
    if (cmd_i.div_prev) begin
      lp_q   <= leaps;
      prod_q <= prod_d;
    end
    if (cmd_i.div_cur) begin
      lyin_q <= is_leap;
    end
    if (cmd_i.n_step) begin
      n_q        <= n_q - (15'(DAYS_COMMON) + 15'(c400_leap));
      prevleap_q <= c400_leap;
      year_q     <= year_q + YearW'(1);
      c400_q     <= (c400_q == 9'd399) ? 9'd0 : (c400_q + 9'd1);
    end
    if (cmd_i.n_fix) begin
      if (n_q == '0) begin
        // day zero is the last day of the year before
        year_q <= year_q - YearW'(1);
        n_q    <= 15'(DAYS_COMMON) + 15'(prevleap_q);
        ly_q   <= prevleap_q;
      end else begin
        ly_q <= c400_leap;
      end
    end
    if (cmd_i.d_sum) begin
      out_q.day_number_out <= dn;
      out_q.year_out       <= '0;
      out_q.month_out      <= '0;
      out_q.day_out        <= '0;
    end
    if (cmd_i.n_month) begin
      out_q.day_number_out <= '0;
      out_q.year_out       <= year_q[YEAR_W-1:0];
      out_q.month_out      <= mon;
      out_q.day_out        <= day_rem[DAY_W-1:0];
    end
  end

  assign sts_o.opcode    = opcode_q;
  assign sts_o.walk_done = n_q <= 15'(DAYS_COMMON);
  assign out_o           = out_q;

endmodule

`default_nettype wire

[src/cdnc_ctrl.sv]
`default_nettype none

module cdnc_ctrl import cdnc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUTE,
    ST_D_PREV,
    ST_D_CUR,
    ST_D_SUM,
    ST_N_WALK,
    ST_N_FIX,
    ST_N_MONTH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // Result register can take a new value
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and datapath commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ROUTE;
        end
      end
      ST_ROUTE: begin
        state_d = (sts_i.opcode == OP_NUM_TO_DATE) ? ST_N_WALK : ST_D_PREV;
      end
      ST_D_PREV: begin
        cmd_o.div_prev = 1'b1;
        state_d        = ST_D_CUR;
      end
      ST_D_CUR: begin
        cmd_o.div_cur = 1'b1;
        state_d       = ST_D_SUM;
      end
      ST_D_SUM: begin
        if (slot_free) begin
          cmd_o.d_sum = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_N_WALK: begin
        if (sts_i.walk_done) begin
          state_d = ST_N_FIX;
        end else begin
          cmd_o.n_step = 1'b1;
        end
      end
      ST_N_FIX: begin
        cmd_o.n_fix = 1'b1;
        state_d     = ST_N_MONTH;
      end
      ST_N_MONTH: begin
        if (slot_free) begin
          cmd_o.n_month = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[src/calendar_day_number_converter.sv]
`default_nettype none
// Date to day number: capture, route, leap count through year-1, leap flag
// of the input year, then the final sum. Day number to date: capture, route,
// a walk over whole years (up to 89 for a 15-bit day number), one year per
// cycle, then day-zero fix and month search. One item at a time; a result
// still waiting in the output register holds the next item at its final step.
// Reset: asynchronous active low; clears the controller and the output valid.
module calendar_day_number_converter import cdnc_pkg::*; #(
  parameter int BASE_YEAR = BASE_YEAR_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  cdnc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cdnc_dpath #(
    .BASE_YEAR (BASE_YEAR)
  ) u_dpath (
    .clk_i (clk_i),
    .in_i  (in_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .out_o (out_o)
  );

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import cdnc_pkg::*;

  localparam int BASE_YEAR = BASE_YEAR_DEF;
  localparam int unsigned CYCLE_DAYS = 146097;
  localparam int unsigned MONTH_START [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };
  localparam int N_RANDOM = 1700;
  localparam int HOLD_AT = 200;    // output transfer count that starts the long hold
  localparam int HOLD_LEN = 400;
  localparam int DRAIN_CYCLES = 120;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  in_t  pend_q [$];
  out_t conv_q [$];
  int   n_items = 0;
  int   n_in_xfer = 0;
  int   n_out_xfer = 0;
  int   n_errors = 0;
  logic in_taken = 1'b0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  int   tx_idle_pct;
  int   rx_idle_pct;

  calendar_day_number_converter #(
    .BASE_YEAR(BASE_YEAR)
  ) u_top (
    .clk_i(clk),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_i(in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o(out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gregorian leap rule
  function automatic bit leap_gregorian(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // leap years in 1..y
  function automatic int unsigned leaps_up_to(input int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  function automatic logic [DN_W-1:0] date_to_day_number(input int unsigned y,
                                                         input int unsigned m,
                                                         input int unsigned d);
    int unsigned mon;
    int unsigned n;
    mon = m;
    n = 0;
    if (mon < 1) mon = 1;
    if (mon > 12) mon = 12;
    if (y > BASE_YEAR) begin
      n = 365 * (y - BASE_YEAR) + leaps_up_to(y - 1) - leaps_up_to(BASE_YEAR - 1);
    end
    n += MONTH_START[mon-1];
    if (mon > 2 && leap_gregorian(y)) n += 1;
    n += d;
    return n[DN_W-1:0];
  endfunction

  function automatic out_t day_number_to_date(input int unsigned dn);
    out_t r;
    int unsigned n;
    int unsigned yr;
    int unsigned mon;
    bit ly;
    r = '0;
    yr = BASE_YEAR + (dn / CYCLE_DAYS) * 400;
    n = dn % CYCLE_DAYS;
    // walk whole years
    while (n > 365) begin
      n -= 365 + (leap_gregorian(yr) ? 1 : 0);
      yr++;
    end
    // day zero is the last day of the previous year
    if (n == 0) begin
      yr--;
      n = 365 + (leap_gregorian(yr) ? 1 : 0);
    end
    ly = leap_gregorian(yr);
    // first month whose last day reaches n; scanning down keeps the lowest
    mon = 12;
    for (int k = 11; k >= 0; k--) begin
      if (MONTH_START[k] + ((ly && k > 1) ? 1 : 0) >= n) mon = k;
    end
    if (ly && mon > 2) n--;
    n -= MONTH_START[mon-1];
    r.year_out = yr[YEAR_W-1:0];
    r.month_out = mon[MONTH_W-1:0];
    r.day_out = n[DAY_W-1:0];
    return r;
  endfunction

  function automatic out_t predict_conversion(input in_t it);
    out_t r;
    r = '0;
    if (it.opcode == OP_DATE_TO_NUM) begin
      r.day_number_out = date_to_day_number(it.year_in, it.month_in, it.day_in);
    end else begin
      r = day_number_to_date(it.day_number_in);
    end
    return r;
  endfunction

  function automatic in_t make_item(input logic op, input int unsigned y,
                                    input int unsigned m, input int unsigned d,
                                    input int unsigned dn);
    in_t it;
    it.opcode = op;
    it.year_in = y[YEAR_W-1:0];
    it.month_in = m[MONTH_W-1:0];
    it.day_in = d[DAY_W-1:0];
    it.day_number_in = dn[DN_W-1:0];
    return it;
  endfunction

  // Idle rates per phase, switched on input transfer count
  always_comb begin
    if (n_in_xfer < n_items / 3) begin
      tx_idle_pct = 28;
      rx_idle_pct = 70;
    end else if (n_in_xfer < (2 * n_items) / 3) begin
      tx_idle_pct = 70;
      rx_idle_pct = 28;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  end

  // Input driver: next item once the current one has transferred
  always @(negedge clk) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pend_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pend_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, once
  always @(posedge clk) begin
    if (n_out_xfer == HOLD_AT && !hold_done) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Output ready
  always @(negedge clk) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    out_t want;
    in_taken <= in_valid && in_ready && rst_ni;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        conv_q.push_back(predict_conversion(in_data));
        n_in_xfer++;
      end
      if (out_valid && out_ready) begin
        n_out_xfer++;
        if (conv_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $display("unexpected result: dn=%0d y=%0d m=%0d d=%0d",
                     out_data.day_number_out, out_data.year_out,
                     out_data.month_out, out_data.day_out);
          end
        end else begin
          want = conv_q.pop_front();
          if (out_data.day_number_out !== want.day_number_out ||
              out_data.year_out !== want.year_out ||
              out_data.month_out !== want.month_out ||
              out_data.day_out !== want.day_out) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
              $display("mismatch at result %0d: exp dn=%0d y=%0d m=%0d d=%0d",
                       n_out_xfer, want.day_number_out, want.year_out,
                       want.month_out, want.day_out);
              $display("  got dn=%0d y=%0d m=%0d d=%0d",
                       out_data.day_number_out, out_data.year_out,
                       out_data.month_out, out_data.day_out);
            end
          end
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned y;
    int unsigned m;
    int unsigned len;
    // date to number: base, span ends, leap handling, clamped months, odd days
    pend_q.push_back(make_item(OP_DATE_TO_NUM, 2020, 1, 1, 32767));
    pend_q.push_back(make_item(OP_DATE_TO_NUM, 2083, 12, 31, 0));
    pend_q.push_back(make_item(OP_DATE_TO_NUM, 0, 1, 1, 0));
    pend_q.push_back(make_item(OP_DATE_TO_NUM, 1999, 6, 15, 0));
    pend_q.push_back(make_item(OP_DATE_TO_NUM, 4095, 15, 31, 32767));
    pend_q.push_back(make_item(OP_DATE_TO_NUM, 2024, 0, 5, 0));
    pend_q.push_back(make_item(OP_DATE_TO_NUM, 2024, 13, 5, 0));
    pend_q.push_back(make_item(OP_DATE_TO_NUM, 2024, 2, 29, 0));
    pend_q.push_back(make_item(OP_DATE_TO_NUM, 2024, 3, 0, 0));
    pend_q.push_back(make_item(OP_DATE_TO_NUM, 2100, 3, 1, 0));
    pend_q.push_back(make_item(OP_DATE_TO_NUM, 2400, 3, 1, 0));
    pend_q.push_back(make_item(OP_DATE_TO_NUM, 2200, 2, 31, 0));
    // number to date: day zero, year edges, leap day, range end, widest value
    pend_q.push_back(make_item(OP_NUM_TO_DATE, 4095, 15, 31, 0));
    pend_q.push_back(make_item(OP_NUM_TO_DATE, 0, 0, 0, 1));
    pend_q.push_back(make_item(OP_NUM_TO_DATE, 0, 0, 0, 60));
    pend_q.push_back(make_item(OP_NUM_TO_DATE, 0, 0, 0, 61));
    pend_q.push_back(make_item(OP_NUM_TO_DATE, 0, 0, 0, 365));
    pend_q.push_back(make_item(OP_NUM_TO_DATE, 0, 0, 0, 366));
    pend_q.push_back(make_item(OP_NUM_TO_DATE, 0, 0, 0, 367));
    pend_q.push_back(make_item(OP_NUM_TO_DATE, 0, 0, 0, 731));
    pend_q.push_back(make_item(OP_NUM_TO_DATE, 0, 0, 0, 23376));
    pend_q.push_back(make_item(OP_NUM_TO_DATE, 0, 0, 0, 16384));
    pend_q.push_back(make_item(OP_NUM_TO_DATE, 0, 0, 0, 32767));

    // random items, mostly valid dates and in-range day numbers
    repeat (N_RANDOM) begin
      if ($urandom_range(1) == 0) begin
        if ($urandom_range(99) < 75) begin
          y = ($urandom_range(9) == 0) ? $urandom_range(2150, 1950)
                                       : $urandom_range(2083, 2020);
          m = $urandom_range(12, 1);
          len = (m == 12) ? 31 : MONTH_START[m] - MONTH_START[m-1];
          if (m == 2 && leap_gregorian(y)) len++;
          pend_q.push_back(make_item(OP_DATE_TO_NUM, y, m, $urandom_range(len, 1),
                                     $urandom));
        end else begin
          pend_q.push_back(make_item(OP_DATE_TO_NUM, $urandom, $urandom, $urandom,
                                     $urandom));
        end
      end else begin
        pend_q.push_back(make_item(OP_NUM_TO_DATE, $urandom, $urandom, $urandom,
                                   ($urandom_range(99) < 85) ? $urandom_range(23376)
                                                             : $urandom));
      end
    end
    n_items = pend_q.size();

    // hold reset, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // drain, then let the block settle
    while (pend_q.size() != 0 || in_valid || conv_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Timeout
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
src/cdnc_pkg.sv
src/cdnc_dpath.sv
src/cdnc_ctrl.sv
src/calendar_day_number_converter.sv
tb/tb_top.sv
